[src/sorted_list_insert_delete_assert.svh]
// ----------------------------------------------------------------------------
// Sorted list assertion macros
// Shared forms for the concurrent checks of the sorted list block.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define SLID_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define SLID_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) \
        else $error(msg);

`endif

[src/slid_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted list package
// Codes, widths and shared types of the sorted list block.
// ----------------------------------------------------------------------------
package slid_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 3;
    localparam int CMD_W        = 2;
    localparam int COUNT_W      = 7;
    localparam int DEF_CAPACITY = 32;
    localparam int OUT_TDATA_W  = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_DUMP      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t           op;
        logic [DATA_W-1:0]  key;
        logic [COUNT_W-1:0] count;
    } cell_ctrl_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  value;
        logic [POS_W-1:0]   position;
        logic               last;
    } result_t;

endpackage

[src/sorted_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// Sorted list insert / delete / dump
// Ascending list of signed words held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: s_tdata carries the value, s_tuser the command
//   (insert, delete, dump). Master channel: m_tdata carries the entry value
//   and the position, m_tuser the status, m_tlast marks the final beat of a
//   command.
//   Insert and delete act on all cells at once in the accept cycle; their one
//   result beat goes to the output register, or to the hold stage on a stall.
//   A new command may be taken every cycle while the receiver keeps up.
//   A dump of N entries gives N beats, one per cycle while the receiver keeps
//   up, by rotating the cell row one place per beat (cell 0 is the read
//   point); the row is back in order after the last beat. The next command is
//   taken after the last beat has been handed to the output register.
//   A result register and a one-beat hold stage sit on the master side, so
//   one command is still taken while a result waits; further commands stall
//   until the receiver takes beats. A stalled beat holds steady.
//   Reset clears the entry count and the output valids; the cell contents
//   need no reset since entries beyond the count are never read.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete
    import slid_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata: value[31:0]
    input  logic [DATA_W-1:0]      s_tdata,
    // s_tuser: command[1:0]
    input  logic [CMD_W-1:0]       s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // m_tdata: entry_value[31:0], position[37:32], zero pad[39:38]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: status[2:0]
    output logic [STATUS_W-1:0]    m_tuser,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready
);

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] dump_idx_reg, dump_idx_next;
    logic               m_valid_reg, m_valid_next;
    result_t            out_reg, out_next;
    logic               hold_valid_reg, hold_valid_next;
    result_t            hold_reg, hold_next;

    cell_ctrl_t         ctrl;
    result_t            res;
    logic               res_valid;
    logic               accept;
    logic               out_free;
    logic               found;
    logic               dump_last;

    logic [DATA_W-1:0]  val_w   [CAPACITY];
    logic [CAPACITY-1:0] gt_w;
    logic [CAPACITY-1:0] ge_w;
    logic [CAPACITY-1:0] match_w;

    // Cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] lv, rv;
        logic              lg, lge;
        if (i == 0) begin : g_head
            assign lv  = ctrl.key;
            assign lg  = 1'b1;
            assign lge = 1'b0;
        end else begin : g_mid
            assign lv  = val_w[i-1];
            assign lg  = gt_w[i-1];
            assign lge = ge_w[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign rv = val_w[i];
        end else begin : g_body
            assign rv = val_w[i+1];
        end
        slid_cell #(
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .left_val  (lv),
            .left_gt   (lg),
            .left_ge   (lge),
            .right_val (rv),
            .head_val  (val_w[0]),
            .val       (val_w[i]),
            .gt        (gt_w[i]),
            .ge        (ge_w[i]),
            .match     (match_w[i])
        );
    end

    assign found     = |match_w;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && !hold_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign dump_last = (dump_idx_reg == count_reg - COUNT_W'(1));

    // Sequence commands and drive the cell row
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        ctrl.op       = CELL_HOLD;
        ctrl.key      = s_tdata;
        ctrl.count    = count_reg;
        res_valid     = 1'b0;
        res.status    = ST_DONE;
        res.value     = s_tdata;
        res.position  = '0;
        res.last      = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        CMD_INSERT: begin
                            res_valid = 1'b1;
                            if (count_reg == COUNT_W'(CAPACITY)) begin
                                res.status = ST_FULL;
                            end else begin
                                ctrl.op    = CELL_INS;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        CMD_DELETE: begin
                            res_valid = 1'b1;
                            if (found) begin
                                ctrl.op    = CELL_DEL;
                                count_next = count_reg - COUNT_W'(1);
                            end else begin
                                res.status = ST_NOT_FOUND;
                            end
                        end
                        CMD_DUMP: begin
                            if (count_reg == '0) begin
                                res_valid  = 1'b1;
                                res.status = ST_EMPTY;
                            end else begin
                                state_next    = S_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        default: begin
                            // unused code: drop the beat
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (out_free && !hold_valid_reg) begin
                    res_valid     = 1'b1;
                    res.status    = ST_DUMP;
                    res.value     = val_w[0];
                    res.position  = POS_W'(dump_idx_reg + COUNT_W'(1));
                    res.last      = dump_last;
                    ctrl.op       = CELL_ROT;
                    dump_idx_next = dump_idx_reg + COUNT_W'(1);
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Route results through the output register and the hold stage
    always_comb begin
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (out_free) begin
            if (hold_valid_reg) begin
                m_valid_next    = 1'b1;
                out_next        = hold_reg;
                hold_valid_next = 1'b0;
            end else if (res_valid) begin
                m_valid_next = 1'b1;
                out_next     = res;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            hold_valid_next = 1'b1;
            hold_next       = res;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            dump_idx_reg   <= '0;
            m_valid_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            dump_idx_reg   <= dump_idx_next;
            m_valid_reg    <= m_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - DATA_W - POS_W){1'b0}}, out_reg.position,
                       out_reg.value};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

endmodule

[src/slid_cell.sv]
// ----------------------------------------------------------------------------
// Sorted list cell
// One list slot: compares its entry with the key and shifts with neighbors.
// ----------------------------------------------------------------------------
module slid_cell
    import slid_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] left_val,
    input  logic              left_gt,
    input  logic              left_ge,
    input  logic [DATA_W-1:0] right_val,
    input  logic [DATA_W-1:0] head_val,
    output logic [DATA_W-1:0] val,
    output logic              gt,
    output logic              ge,
    output logic              match
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic              occ;
    logic              tail;

    // Compare the stored entry with the key
    assign occ   = (COUNT_W'(IDX) < ctrl.count);
    assign tail  = (ctrl.count == COUNT_W'(IDX + 1));
    assign gt    = occ && ($signed(ctrl.key) > $signed(val_reg));
    assign ge    = occ && !gt;
    assign match = ge && !left_ge && (val_reg == ctrl.key);
    assign val   = val_reg;

    // Pick the next entry from self, key, a neighbor or the head cell
    always_comb begin
        val_next = val_reg;
        case (ctrl.op)
            CELL_INS: begin
                if (!gt) begin
                    val_next = left_gt ? ctrl.key : left_val;
                end
            end
            CELL_DEL: begin
                if (ge) begin
                    val_next = right_val;
                end
            end
            CELL_ROT: begin
                val_next = tail ? head_val : right_val;
            end
            default: begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

[src/slid_checker.sv]
// ----------------------------------------------------------------------------
// Sorted list port checker
// Watches the master channel of the sorted list block.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_delete_assert.svh"

module slid_checker
    import slid_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]    m_tuser,
    input logic                   m_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready
);

    // Hold a stalled beat
    `SLID_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled beat changed")

    // Single-beat results always close their command
    `SLID_ASSERT_NOW(a_single_last, m_tvalid && (m_tuser != ST_DUMP), m_tlast, "non-dump beat without last")

    // Position is zero outside a dump
    `SLID_ASSERT_NOW(a_pos_zero, m_tvalid && (m_tuser != ST_DUMP), m_tdata[37:32] == 6'd0, "position set outside dump")

    // Dump beats count up by one within a run
    `SLID_ASSERT_NEXT(a_dump_step, m_tvalid && m_tready && (m_tuser == ST_DUMP) && !m_tlast && (m_tdata[37:32] != 6'd63), !m_tvalid || ((m_tuser == ST_DUMP) && (m_tdata[37:32] == $past(m_tdata[37:32]) + 6'd1)), "dump position skipped")

endmodule

bind sorted_list_insert_delete slid_checker u_slid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
